// File: src/ecp_pkg.sv
// Shared types and constants for the elliptic-curve ElGamal point cipher.
`default_nettype none
package ecp_pkg;

  // Serial field unit operation: restoring divide with quotient*m, or m*n.
  typedef enum logic {
    FU_DIV = 1'b0,
    FU_MUL = 1'b1
  } fu_mode_t;

  typedef struct packed {
    logic     start;
    fu_mode_t mode;
  } fu_req_t;

  typedef enum logic {
    ACT_ENCRYPT = 1'b0,
    ACT_DECRYPT = 1'b1
  } action_t;

  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_X  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_Y  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PUB_X   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PUB_Y   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SECRET  = 3'd5;

  localparam int MODULUS_RESET = 751;
  localparam int BASE_Y_RESET  = 1;

endpackage
`default_nettype wire

// File: src/ecp_in_if.sv
// Input channel: one cipher request per transaction.
`default_nettype none
interface ecp_in_if #(
  parameter int COORD_BITS  = 16,
  parameter int SCALAR_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_BITS-1:0]  first_x;
  logic [COORD_BITS-1:0]  first_y;
  logic [COORD_BITS-1:0]  second_x;
  logic [COORD_BITS-1:0]  second_y;
  logic [SCALAR_BITS-1:0] nonce;

  modport source (output valid, action, first_x, first_y, second_x, second_y, nonce,
                  input ready);
  modport sink (input valid, action, first_x, first_y, second_x, second_y, nonce,
                output ready);
endinterface
`default_nettype wire

// File: src/ecp_out_if.sv
// Output channel: one pair of result points per transaction.
`default_nettype none
interface ecp_out_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] out_a_x;
  logic [COORD_BITS-1:0] out_a_y;
  logic [COORD_BITS-1:0] out_b_x;
  logic [COORD_BITS-1:0] out_b_y;

  modport source (output valid, out_a_x, out_a_y, out_b_x, out_b_y, input ready);
  modport sink (input valid, out_a_x, out_a_y, out_b_x, out_b_y, output ready);
endinterface
`default_nettype wire

// File: src/ecp_serial.sv
// Bit-serial modular unit: multiply, or divide with quotient*m folded in.
`default_nettype none
module ecp_serial #(
  parameter int COORD_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  ecp_pkg::fu_req_t       req,
  input  wire [COORD_BITS-1:0]   n,
  input  wire [COORD_BITS-1:0]   d,
  input  wire [COORD_BITS-1:0]   m,
  input  wire [COORD_BITS-1:0]   fm,
  output logic                   done,
  output logic [COORD_BITS-1:0]  rem,
  output logic [COORD_BITS-1:0]  prod
);
  import ecp_pkg::*;

  localparam int CNT_W = $clog2(COORD_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  fu_mode_t              mode;
  logic [COORD_BITS-1:0] nsh;
  logic [COORD_BITS-1:0] dr;
  logic [COORD_BITS-1:0] mr;
  logic [COORD_BITS-1:0] fmr;
  logic [COORD_BITS-1:0] remr;
  logic [COORD_BITS-1:0] accr;

  logic                  bit_in;
  logic [COORD_BITS:0]   rsh;
  logic                  ge;
  logic [COORD_BITS:0]   rdiff;
  logic                  qbit;
  logic [COORD_BITS-1:0] a2;
  logic [COORD_BITS-1:0] acc_next;
  logic [COORD_BITS-1:0] rem_next;

  function automatic logic [COORD_BITS-1:0] fadd(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b,
                                                 input logic [COORD_BITS-1:0] p);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[COORD_BITS-1:0];
  endfunction

  always_comb begin
    bit_in   = nsh[COORD_BITS-1];
    rsh      = {remr, bit_in};
    ge       = (rsh >= {1'b0, dr});
    rdiff    = rsh - {1'b0, dr};
    rem_next = ge ? rdiff[COORD_BITS-1:0] : rsh[COORD_BITS-1:0];
    qbit     = (mode == FU_MUL) ? bit_in : ge;
    a2       = fadd(accr, accr, fmr);
    acc_next = qbit ? fadd(a2, mr, fmr) : a2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mode <= req.mode;
        nsh  <= n;
        dr   <= d;
        mr   <= m;
        fmr  <= fm;
        remr <= '0;
        accr <= '0;
      end else if (busy) begin
        nsh  <= nsh << 1;
        remr <= rem_next;
        accr <= acc_next;
        if (cnt == CNT_W'(COORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  assign rem  = remr;
  assign prod = accr;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("serial unit restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a running operation");
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    busy |-> (accr < fmr))
    else $error("accumulator left the field");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (busy && mode == FU_DIV && cnt != '0) |-> (remr < dr))
    else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

// File: src/ecp_seq.sv
// Point-level sequencer: reduction, scalar multiply, point add, inversion.
`default_nettype none
module ecp_seq #(
  parameter int COORD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  input  wire                    action,
  input  wire [COORD_BITS-1:0]   first_x,
  input  wire [COORD_BITS-1:0]   first_y,
  input  wire [COORD_BITS-1:0]   second_x,
  input  wire [COORD_BITS-1:0]   second_y,
  input  wire [SCALAR_BITS-1:0]  nonce,
  input  wire [COORD_BITS-1:0]   modulus,
  input  wire [COORD_BITS-1:0]   base_x,
  input  wire [COORD_BITS-1:0]   base_y,
  input  wire [COORD_BITS-1:0]   pub_x,
  input  wire [COORD_BITS-1:0]   pub_y,
  input  wire [SCALAR_BITS-1:0]  secret_scalar,
  output logic                   idle,
  output logic                   res_valid,
  input  wire                    res_take,
  output logic [COORD_BITS-1:0]  ra_x,
  output logic [COORD_BITS-1:0]  ra_y,
  output logic [COORD_BITS-1:0]  rb_x,
  output logic [COORD_BITS-1:0]  rb_y,
  output ecp_pkg::fu_req_t       fu_req,
  output logic [COORD_BITS-1:0]  fu_n,
  output logic [COORD_BITS-1:0]  fu_d,
  output logic [COORD_BITS-1:0]  fu_m,
  output logic [COORD_BITS-1:0]  fu_fm,
  input  wire                    fu_done,
  input  wire [COORD_BITS-1:0]   fu_rem,
  input  wire [COORD_BITS-1:0]   fu_prod
);
  import ecp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_REDW, S_SETUP, S_STEP, S_DBL, S_MEND, S_CHK, S_SQW,
    S_TRI, S_NUM, S_INV, S_DIVW, S_EUC, S_LAMW, S_L2W, S_RX, S_DX, S_DXW,
    S_RET, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_ANS,
    SEL_DBL,
    SEL_FIN
  } sel_t;

  state_t                 state;
  sel_t                   sel;
  action_t                act;
  logic                   phase;
  logic [COORD_BITS-1:0]  fm;
  logic [COORD_BITS-1:0]  v [6];
  logic [2:0]             idx;
  logic [SCALAR_BITS-1:0] k;
  logic [SCALAR_BITS-1:0] kseed;
  logic [COORD_BITS-1:0]  accx, accy, ansx, ansy;
  logic [COORD_BITS-1:0]  num, den, lam;
  logic [COORD_BITS-1:0]  r0, r1, t0, t1;
  logic [COORD_BITS-1:0]  wx, wy;

  logic [COORD_BITS-1:0]  ux, uy, vx, vy;
  logic [2:0]             last_idx;

  function automatic logic [COORD_BITS-1:0] fadd(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b,
                                                 input logic [COORD_BITS-1:0] p);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[COORD_BITS-1:0];
  endfunction

  // a - b mod p for a, b < p; the true result is below p, so wrap is harmless
  function automatic logic [COORD_BITS-1:0] fsub(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b,
                                                 input logic [COORD_BITS-1:0] p);
    logic [COORD_BITS:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, p} - {1'b0, b};
    end
    return s[COORD_BITS-1:0];
  endfunction

  always_comb begin
    unique case (sel)
      SEL_ANS: begin
        ux = ansx; uy = ansy; vx = accx; vy = accy;
      end
      SEL_DBL: begin
        ux = accx; uy = accy; vx = accx; vy = accy;
      end
      default: begin
        ux = (act == ACT_DECRYPT) ? v[2] : v[0];
        uy = (act == ACT_DECRYPT) ? v[3] : v[1];
        vx = ansx; vy = ansy;
      end
    endcase
    last_idx = (act == ACT_DECRYPT) ? 3'd3 : 3'd5;
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_FIN);
  assign fu_fm     = fm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fu_req <= '{start: 1'b0, mode: FU_DIV};
    end else begin
      fu_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action_t'(action);
            fm    <= modulus;
            idx   <= '0;
            phase <= 1'b0;
            v[0]  <= first_x;
            v[1]  <= first_y;
            if (action_t'(action) == ACT_DECRYPT) begin
              v[2]  <= second_x;
              v[3]  <= second_y;
              v[4]  <= '0;
              v[5]  <= '0;
              kseed <= secret_scalar;
            end else begin
              v[2]  <= base_x;
              v[3]  <= base_y;
              v[4]  <= pub_x;
              v[5]  <= pub_y;
              kseed <= nonce;
            end
            if (modulus < COORD_BITS'(2)) begin
              ra_x  <= '0;
              ra_y  <= '0;
              rb_x  <= '0;
              rb_y  <= '0;
              state <= S_FIN;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          fu_req <= '{start: 1'b1, mode: FU_DIV};
          fu_n   <= v[idx];
          fu_d   <= fm;
          fu_m   <= '0;
          state  <= S_REDW;
        end
        S_REDW: begin
          if (fu_done) begin
            v[idx] <= fu_rem;
            if (idx == last_idx) begin
              state <= S_SETUP;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RED;
            end
          end
        end
        S_SETUP: begin
          ansx <= '0;
          ansy <= '0;
          k    <= kseed;
          if (act == ACT_DECRYPT) begin
            accx <= v[0];
            accy <= fsub('0, v[1], fm);
          end else if (!phase) begin
            accx <= v[2];
            accy <= v[3];
          end else begin
            accx <= v[4];
            accy <= v[5];
          end
          state <= S_STEP;
        end
        S_STEP: begin
          if (k == '0) begin
            state <= S_MEND;
          end else if (k[0]) begin
            sel   <= SEL_ANS;
            state <= S_CHK;
          end else begin
            state <= S_DBL;
          end
        end
        S_DBL: begin
          k <= k >> 1;
          // last doubling is never used
          if ((k >> 1) == '0) begin
            state <= S_MEND;
          end else begin
            sel   <= SEL_DBL;
            state <= S_CHK;
          end
        end
        S_MEND: begin
          if (act == ACT_ENCRYPT && !phase) begin
            ra_x  <= ansx;
            ra_y  <= ansy;
            phase <= 1'b1;
            state <= S_SETUP;
          end else begin
            sel   <= SEL_FIN;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (ux == '0 && uy == '0) begin
            wx    <= vx;
            wy    <= vy;
            state <= S_RET;
          end else if (vx == '0 && vy == '0) begin
            wx    <= ux;
            wy    <= uy;
            state <= S_RET;
          end else if (ux == vx && uy == vy) begin
            fu_req <= '{start: 1'b1, mode: FU_MUL};
            fu_n   <= ux;
            fu_m   <= ux;
            state  <= S_SQW;
          end else begin
            num   <= fsub(uy, vy, fm);
            den   <= fsub(ux, vx, fm);
            state <= S_INV;
          end
        end
        S_SQW: begin
          if (fu_done) begin
            lam   <= fu_prod;
            num   <= fadd(fu_prod, fu_prod, fm);
            state <= S_TRI;
          end
        end
        S_TRI: begin
          num   <= fadd(num, lam, fm);
          state <= S_NUM;
        end
        S_NUM: begin
          // 3x^2 + a with a = -1
          num   <= fsub(num, COORD_BITS'(1), fm);
          den   <= fadd(uy, uy, fm);
          state <= S_INV;
        end
        S_INV: begin
          if (den == '0) begin
            wx    <= '0;
            wy    <= '0;
            state <= S_RET;
          end else begin
            r0     <= fm;
            r1     <= den;
            t0     <= '0;
            t1     <= COORD_BITS'(1);
            fu_req <= '{start: 1'b1, mode: FU_DIV};
            fu_n   <= fm;
            fu_d   <= den;
            fu_m   <= COORD_BITS'(1);
            state  <= S_DIVW;
          end
        end
        S_DIVW: begin
          // one Euclid step: remainder and t0 - q*t1
          if (fu_done) begin
            r0    <= r1;
            r1    <= fu_rem;
            t0    <= t1;
            t1    <= fsub(t0, fu_prod, fm);
            state <= S_EUC;
          end
        end
        S_EUC: begin
          if (r1 == '0) begin
            if (r0 != COORD_BITS'(1)) begin
              wx    <= '0;
              wy    <= '0;
              state <= S_RET;
            end else begin
              fu_req <= '{start: 1'b1, mode: FU_MUL};
              fu_n   <= num;
              fu_m   <= t0;
              state  <= S_LAMW;
            end
          end else begin
            fu_req <= '{start: 1'b1, mode: FU_DIV};
            fu_n   <= r0;
            fu_d   <= r1;
            fu_m   <= t1;
            state  <= S_DIVW;
          end
        end
        S_LAMW: begin
          if (fu_done) begin
            lam    <= fu_prod;
            fu_req <= '{start: 1'b1, mode: FU_MUL};
            fu_n   <= fu_prod;
            fu_m   <= fu_prod;
            state  <= S_L2W;
          end
        end
        S_L2W: begin
          if (fu_done) begin
            wx    <= fsub(fu_prod, ux, fm);
            state <= S_RX;
          end
        end
        S_RX: begin
          wx    <= fsub(wx, vx, fm);
          state <= S_DX;
        end
        S_DX: begin
          fu_req <= '{start: 1'b1, mode: FU_MUL};
          fu_n   <= lam;
          fu_m   <= fsub(ux, wx, fm);
          state  <= S_DXW;
        end
        S_DXW: begin
          if (fu_done) begin
            wy    <= fsub(fu_prod, uy, fm);
            state <= S_RET;
          end
        end
        S_RET: begin
          unique case (sel)
            SEL_ANS: begin
              ansx  <= wx;
              ansy  <= wy;
              state <= S_DBL;
            end
            SEL_DBL: begin
              accx  <= wx;
              accy  <= wy;
              state <= S_STEP;
            end
            default: begin
              if (act == ACT_DECRYPT) begin
                ra_x <= wx;
                ra_y <= wy;
                rb_x <= '0;
                rb_y <= '0;
              end else begin
                rb_x <= wx;
                rb_y <= wy;
              end
              state <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/ec_elgamal_point_cipher.sv
// Top level of the elliptic-curve ElGamal point cipher.
//
//   channel | dir | handshake       | carries
//   --------+-----+-----------------+------------------------------------------
//   in_ch   | in  | valid/ready     | action, first_x/y, second_x/y, nonce
//   out_ch  | out | valid/ready     | out_a_x/y, out_b_x/y
//   cfg     | in  | cfg_we only     | cfg_index, cfg_data (no read-back)
//
// One request is worked at a time. All field arithmetic runs on the
// bit-serial field unit; a point add is up to four multiplies plus up to
// about 1.5*COORD_BITS Euclid steps. An item runs up to 2*SCALAR_BITS
// point adds per scalar multiply, fewer for short scalars.
// Reset (rst, synchronous) loads the default curve registers and idles the
// sequencer. A finished result sits in the output register while the next
// request is accepted; the sequencer only stalls if that register is full.
`default_nettype none
module ec_elgamal_point_cipher #(
  parameter int COORD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire [ecp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire [((COORD_BITS > SCALAR_BITS) ? COORD_BITS : SCALAR_BITS)-1:0] cfg_data,
  ecp_in_if.sink                                in_ch,
  ecp_out_if.source                             out_ch
);
  import ecp_pkg::*;

  // configuration registers
  logic [COORD_BITS-1:0]  modulus;
  logic [COORD_BITS-1:0]  base_x;
  logic [COORD_BITS-1:0]  base_y;
  logic [COORD_BITS-1:0]  pub_x;
  logic [COORD_BITS-1:0]  pub_y;
  logic [SCALAR_BITS-1:0] secret_scalar;

  // output register
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_a_x, out_a_y, out_b_x, out_b_y;

  logic                  seq_idle;
  logic                  res_valid;
  logic                  res_take;
  logic                  in_take;
  logic [COORD_BITS-1:0] ra_x, ra_y, rb_x, rb_y;

  fu_req_t               fu_req;
  logic [COORD_BITS-1:0] fu_n, fu_d, fu_m, fu_fm;
  logic                  fu_done;
  logic [COORD_BITS-1:0] fu_rem, fu_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= COORD_BITS'(MODULUS_RESET);
      base_x        <= '0;
      base_y        <= COORD_BITS'(BASE_Y_RESET);
      pub_x         <= '0;
      pub_y         <= '0;
      secret_scalar <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: modulus       <= cfg_data[COORD_BITS-1:0];
        REG_BASE_X:  base_x        <= cfg_data[COORD_BITS-1:0];
        REG_BASE_Y:  base_y        <= cfg_data[COORD_BITS-1:0];
        REG_PUB_X:   pub_x         <= cfg_data[COORD_BITS-1:0];
        REG_PUB_Y:   pub_y         <= cfg_data[COORD_BITS-1:0];
        REG_SECRET:  secret_scalar <= cfg_data[SCALAR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = seq_idle;
  assign in_take     = in_ch.valid && seq_idle;
  // result moves to the output register once it is empty or being drained
  assign res_take    = res_valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid <= 1'b1;
        out_a_x   <= ra_x;
        out_a_y   <= ra_y;
        out_b_x   <= rb_x;
        out_b_y   <= rb_y;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.out_a_x = out_a_x;
  assign out_ch.out_a_y = out_a_y;
  assign out_ch.out_b_x = out_b_x;
  assign out_ch.out_b_y = out_b_y;

  ecp_seq #(
    .COORD_BITS  (COORD_BITS),
    .SCALAR_BITS (SCALAR_BITS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (in_take),
    .action        (in_ch.action),
    .first_x       (in_ch.first_x),
    .first_y       (in_ch.first_y),
    .second_x      (in_ch.second_x),
    .second_y      (in_ch.second_y),
    .nonce         (in_ch.nonce),
    .modulus       (modulus),
    .base_x        (base_x),
    .base_y        (base_y),
    .pub_x         (pub_x),
    .pub_y         (pub_y),
    .secret_scalar (secret_scalar),
    .idle          (seq_idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .ra_x          (ra_x),
    .ra_y          (ra_y),
    .rb_x          (rb_x),
    .rb_y          (rb_y),
    .fu_req        (fu_req),
    .fu_n          (fu_n),
    .fu_d          (fu_d),
    .fu_m          (fu_m),
    .fu_fm         (fu_fm),
    .fu_done       (fu_done),
    .fu_rem        (fu_rem),
    .fu_prod       (fu_prod)
  );

  ecp_serial #(
    .COORD_BITS (COORD_BITS)
  ) u_serial (
    .clk  (clk),
    .rst  (rst),
    .req  (fu_req),
    .n    (fu_n),
    .d    (fu_d),
    .m    (fu_m),
    .fm   (fu_fm),
    .done (fu_done),
    .rem  (fu_rem),
    .prod (fu_prod)
  );

endmodule
`default_nettype wire
